@@ src/axis_rotation_3d_macros.svh @@
// ----------------------------------------------------------------------------
// axis_rotation_3d_macros.svh
// Assertion shorthands for the rotation block checkers.
// ----------------------------------------------------------------------------
`ifndef AXIS_ROTATION_3D_MACROS_SVH
`define AXIS_ROTATION_3D_MACROS_SVH

// implication, masked while reset is asserted
`define AROT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, live during reset too
`define AROT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/arot_pkg.sv @@
// ----------------------------------------------------------------------------
// arot_pkg
// Shared types, widths and constants of the principal-axis rotation pipeline.
// ----------------------------------------------------------------------------
package arot_pkg;

  // coordinates are Q16.16; the rotation itself ignores the binary point
  localparam int COORD_W = 32;
  localparam int ANGLE_W = 20;
  localparam int AXIS_W  = 2;
  localparam int TRIG_W  = 32;   // Q2.30 cosine / sine
  localparam int ZW      = 29;   // CORDIC angle, degrees * 2^20
  localparam int PROD_W  = 64;

  localparam int TRIG_STAGES   = 16;
  localparam int ATAN_LEN      = 24;
  localparam int CORDIC_STAGES = (TRIG_STAGES < ATAN_LEN) ? TRIG_STAGES : ATAN_LEN;

  // reduce -> cordic -> select -> multiply -> round/saturate
  localparam int LATENCY = CORDIC_STAGES + 5;

  // angle reduction: 1/256 degree units, quarter turn = 90 degrees
  localparam int QUARTER_TURN = 23040;
  localparam int TURN_OFFSET  = 24 * QUARTER_TURN;  // whole turns, makes any input positive
  localparam int UW           = 21;
  localparam int QW           = 6;
  localparam int RECIP_W      = 17;
  localparam int RECIP_SHIFT  = 31;
  localparam int RECIP        = 93206;              // floor(2^31 / 23040)
  localparam int Z_SHIFT      = 12;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;
  typedef logic signed [ZW-1:0]      zang_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  localparam trig_t GAIN_Q30 = trig_t'(652032874);
  localparam trig_t ONE_Q30  = trig_t'(1073741824);

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    axis_t  axis;
  } point_t;

  typedef struct packed {
    trig_t x;
    trig_t y;
    zang_t z;
  } cordic_vec_t;

  // round(atan(2^-i) in degrees * 2^20)
  localparam zang_t ATAN_TAB [ATAN_LEN] = '{
    29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121,
    29'sd3750058,  29'sd1876857,  29'sd938658,   29'sd469357,
    29'sd234682,   29'sd117342,   29'sd58671,    29'sd29335,
    29'sd14668,    29'sd7334,     29'sd3667,     29'sd1833,
    29'sd917,      29'sd458,      29'sd229,      29'sd115,
    29'sd57,       29'sd29,       29'sd14,       29'sd7
  };

endpackage

@@ src/arot_reduce.sv @@
// ----------------------------------------------------------------------------
// arot_reduce
// Two-stage angle reduction: modulo 360 degrees, quadrant and remainder.
// ----------------------------------------------------------------------------
module arot_reduce (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  arot_pkg::point_t                    in_pt,
  input  logic signed [arot_pkg::ANGLE_W-1:0] angle,
  output logic                                out_valid,
  output arot_pkg::point_t                    out_pt,
  output logic [1:0]                          out_quad,
  output arot_pkg::zang_t                     out_z
);
  import arot_pkg::*;

  logic [UW-1:0]           u_in;
  logic [UW+RECIP_W-1:0]   prod;
  logic                    a_valid;
  point_t                  a_pt;
  logic [UW-1:0]           a_u;
  logic [QW-1:0]           a_q;
  logic [UW-1:0]           rem_raw;
  logic [UW-1:0]           rem;
  logic                    fix;
  logic [QW-1:0]           q_fix;

  // quotient by quarter turns via reciprocal; estimate is low by at most one
  assign u_in = UW'(int'(angle) + TURN_OFFSET);
  assign prod = (UW+RECIP_W)'(u_in) * (UW+RECIP_W)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_pt <= in_pt;
    a_u  <= u_in;
    a_q  <= prod[RECIP_SHIFT +: QW];
  end

  assign rem_raw = a_u - UW'(a_q) * UW'(QUARTER_TURN);
  assign fix     = (rem_raw >= UW'(QUARTER_TURN));
  assign rem     = fix ? (rem_raw - UW'(QUARTER_TURN)) : rem_raw;
  assign q_fix   = a_q + QW'(fix);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_pt   <= a_pt;
    out_quad <= q_fix[1:0];
    out_z    <= zang_t'({rem, Z_SHIFT'(0)});
  end

endmodule

@@ src/arot_cordic.sv @@
// ----------------------------------------------------------------------------
// arot_cordic
// Unrolled rotation-mode CORDIC, one register stage per iteration.
// ----------------------------------------------------------------------------
module arot_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  arot_pkg::point_t  in_pt,
  input  logic [1:0]        in_quad,
  input  arot_pkg::zang_t   in_z,
  output logic              out_valid,
  output arot_pkg::point_t  out_pt,
  output logic [1:0]        out_quad,
  output arot_pkg::trig_t   out_cos,
  output arot_pkg::trig_t   out_sin
);
  import arot_pkg::*;

  logic        vld  [0:CORDIC_STAGES];
  point_t      pt   [0:CORDIC_STAGES];
  logic [1:0]  quad [0:CORDIC_STAGES];
  cordic_vec_t vec  [0:CORDIC_STAGES];

  assign vld[0]   = in_valid;
  assign pt[0]    = in_pt;
  assign quad[0]  = in_quad;
  assign vec[0].x = GAIN_Q30;
  assign vec[0].y = '0;
  assign vec[0].z = in_z;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    trig_t xs;
    trig_t ys;
    zang_t zs;

    assign xs = vec[i].x;
    assign ys = vec[i].y;
    assign zs = vec[i].z;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    // non-negative residual angle turns counterclockwise
    always_ff @(posedge clk) begin
      pt[i+1]   <= pt[i];
      quad[i+1] <= quad[i];
      if (!zs[ZW-1]) begin
        vec[i+1].x <= xs - (ys >>> i);
        vec[i+1].y <= ys + (xs >>> i);
        vec[i+1].z <= zs - ATAN_TAB[i];
      end else begin
        vec[i+1].x <= xs + (ys >>> i);
        vec[i+1].y <= ys - (xs >>> i);
        vec[i+1].z <= zs + ATAN_TAB[i];
      end
    end
  end

  assign out_valid = vld[CORDIC_STAGES];
  assign out_pt    = pt[CORDIC_STAGES];
  assign out_quad  = quad[CORDIC_STAGES];
  assign out_cos   = vec[CORDIC_STAGES].x;
  assign out_sin   = vec[CORDIC_STAGES].y;

endmodule

@@ src/arot_mix.sv @@
// ----------------------------------------------------------------------------
// arot_mix
// Quadrant fold, operand select, matrix multiply, rounding and saturation.
// ----------------------------------------------------------------------------
module arot_mix (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  arot_pkg::point_t  in_pt,
  input  logic [1:0]        in_quad,
  input  arot_pkg::trig_t   in_cos,
  input  arot_pkg::trig_t   in_sin,
  output logic              done,
  output arot_pkg::coord_t  rot_x,
  output arot_pkg::coord_t  rot_y,
  output arot_pkg::coord_t  rot_z
);
  import arot_pkg::*;

  localparam prod_t ROUND_HALF = prod_t'(64'sd536870912);

  function automatic trig_t clamp_unit(input trig_t v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  function automatic coord_t sat_round(input prod_t acc);
    logic signed [PROD_W-31:0] sh;
    sh = $signed(acc[PROD_W-1:30]);
    if (sh > 34'sd2147483647) return {1'b0, {(COORD_W-1){1'b1}}};
    if (sh < -34'sd2147483648) return {1'b1, {(COORD_W-1){1'b0}}};
    return sh[COORD_W-1:0];
  endfunction

  trig_t  cc, ss, c_q, s_q;
  coord_t p_sel, r_sel;

  logic   d_valid;
  point_t d_pt;
  trig_t  d_c, d_s;
  coord_t d_p, d_r;

  logic   m_valid;
  point_t m_pt;
  prod_t  m_pc, m_rs, m_ps, m_rc;

  prod_t  sum1, sum2;
  coord_t out1, out2;

  assign cc = clamp_unit(in_cos);
  assign ss = clamp_unit(in_sin);

  always_comb begin
    case (in_quad)
      2'd0: begin c_q = cc;  s_q = ss;  end
      2'd1: begin c_q = -ss; s_q = cc;  end
      2'd2: begin c_q = -cc; s_q = -ss; end
      default: begin c_q = ss; s_q = -cc; end
    endcase
  end

  // out1 = p*c - r*s, out2 = p*s + r*c; (p, r) chosen per axis
  always_comb begin
    unique case (in_pt.axis)
      AXIS_X:  begin p_sel = in_pt.y; r_sel = in_pt.z; end
      AXIS_Y:  begin p_sel = in_pt.z; r_sel = in_pt.x; end
      AXIS_Z:  begin p_sel = in_pt.x; r_sel = in_pt.y; end
      default: begin p_sel = in_pt.x; r_sel = in_pt.y; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      m_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      d_valid <= in_valid;
      m_valid <= d_valid;
      done    <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_pt <= in_pt;
    d_c  <= c_q;
    d_s  <= s_q;
    d_p  <= p_sel;
    d_r  <= r_sel;
  end

  always_ff @(posedge clk) begin
    m_pt <= d_pt;
    m_pc <= PROD_W'(d_p) * PROD_W'(d_c);
    m_rs <= PROD_W'(d_r) * PROD_W'(d_s);
    m_ps <= PROD_W'(d_p) * PROD_W'(d_s);
    m_rc <= PROD_W'(d_r) * PROD_W'(d_c);
  end

  assign sum1 = m_pc - m_rs + ROUND_HALF;
  assign sum2 = m_ps + m_rc + ROUND_HALF;
  assign out1 = sat_round(sum1);
  assign out2 = sat_round(sum2);

  always_ff @(posedge clk) begin
    unique case (m_pt.axis)
      AXIS_X: begin
        rot_x <= m_pt.x; rot_y <= out1;   rot_z <= out2;
      end
      AXIS_Y: begin
        rot_x <= out2;   rot_y <= m_pt.y; rot_z <= out1;
      end
      AXIS_Z: begin
        rot_x <= out1;   rot_y <= out2;   rot_z <= m_pt.z;
      end
      default: begin
        rot_x <= m_pt.x; rot_y <= m_pt.y; rot_z <= m_pt.z;
      end
    endcase
  end

endmodule

@@ src/axis_rotation_3d.sv @@
// ----------------------------------------------------------------------------
// axis_rotation_3d
// Rotates a Q16.16 point about the x, y or z axis by an angle in 1/256 degree.
// ----------------------------------------------------------------------------
//  channel   | handshake              | beat
//  ----------+------------------------+-------------------------------------
//  input     | start, busy            | vec_x, vec_y, vec_z, angle_deg
//  result    | done (strobe)          | rot_x, rot_y, rot_z
//  config    | cfg_valid, cfg_ready   | cfg_data (rotation axis)
//
//  One beat per cycle in and out; busy stays low.
//  Stages in order: two reduction stages, the CORDIC chain, quadrant/select,
//  multiply, round.
//  The CORDIC iteration chain sets the depth; every stage is a register.
//  Synchronous reset clears the valid bits and sets the axis to x.
//  The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module axis_rotation_3d (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [arot_pkg::COORD_W-1:0] vec_x,
  input  logic signed [arot_pkg::COORD_W-1:0] vec_y,
  input  logic signed [arot_pkg::COORD_W-1:0] vec_z,
  input  logic signed [arot_pkg::ANGLE_W-1:0] angle_deg,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [arot_pkg::AXIS_W-1:0]         cfg_data,
  output logic                                done,
  output logic signed [arot_pkg::COORD_W-1:0] rot_x,
  output logic signed [arot_pkg::COORD_W-1:0] rot_y,
  output logic signed [arot_pkg::COORD_W-1:0] rot_z
);
  import arot_pkg::*;

  axis_t      rotation_axis;
  logic       accept;
  point_t     in_pt;

  logic       r_valid;
  point_t     r_pt;
  logic [1:0] r_quad;
  zang_t      r_z;

  logic       c_valid;
  point_t     c_pt;
  logic [1:0] c_quad;
  trig_t      c_cos, c_sin;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_axis <= AXIS_X;
    end else if (cfg_valid && cfg_ready) begin
      rotation_axis <= axis_t'(cfg_data);
    end
  end

  // axis rides along with each beat
  assign in_pt = '{x: vec_x, y: vec_y, z: vec_z, axis: rotation_axis};

  arot_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_pt     (in_pt),
    .angle     (angle_deg),
    .out_valid (r_valid),
    .out_pt    (r_pt),
    .out_quad  (r_quad),
    .out_z     (r_z)
  );

  arot_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_pt     (r_pt),
    .in_quad   (r_quad),
    .in_z      (r_z),
    .out_valid (c_valid),
    .out_pt    (c_pt),
    .out_quad  (c_quad),
    .out_cos   (c_cos),
    .out_sin   (c_sin)
  );

  arot_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .in_valid (c_valid),
    .in_pt    (c_pt),
    .in_quad  (c_quad),
    .in_cos   (c_cos),
    .in_sin   (c_sin),
    .done     (done),
    .rot_x    (rot_x),
    .rot_y    (rot_y),
    .rot_z    (rot_z)
  );

endmodule

@@ src/arot_checker.sv @@
// ----------------------------------------------------------------------------
// arot_checker
// Port-level timing checks for the rotation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "axis_rotation_3d_macros.svh"

module arot_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  import arot_pkg::*;

  // every result traces back to an accepted input beat
  `AROT_ASSERT_IMPL(a_done_has_beat, done, $past(start && !busy, LATENCY), "result without input beat")

  // a beat captured while reset was high must never come out
  `AROT_ASSERT_IMPL(a_done_not_flushed, done, !$past(rst, LATENCY), "result survived reset")

  `AROT_ASSERT_NEXT(a_rst_flush, rst, !done, "result strobe right after reset")

endmodule

bind axis_rotation_3d arot_checker u_arot_checker (.*);
